### sv/kvcr_pkg.sv
package kvcr_pkg;

    // Configuration port layout.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam int CAP_W      = 3;
    localparam int POLICY_W   = 2;
    localparam int STATUS_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'd1;

    localparam logic [CAP_W-1:0] CAP_RESET = 3'd4;

    typedef enum logic [POLICY_W-1:0] {
        POL_LRU  = 2'd0,
        POL_LFU  = 2'd1,
        POL_FIFO = 2'd2
    } policy_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_MISS     = 3'd0,
        ST_HIT      = 3'd1,
        ST_INSERTED = 3'd2,
        ST_UPDATED  = 3'd3,
        ST_EVICTED  = 3'd4
    } status_t;

endpackage

### sv/key_value_cache_replacement_unit.sv
// Fully associative key-value store with LRU, LFU or FIFO replacement.
//
// Input channel (s_t*): one item is a get or a put. s_tuser carries the
// action, s_tdata the key and the value. Output channel (m_t*): exactly one
// result item per input item, in order. m_tuser carries the status,
// m_tdata the read value and the evicted key.
// Configuration channel (cfg_*): cfg_index 0 selects the policy (a valid
// code clears the store, the unused code is dropped), cfg_index 1 sets how
// many entries may be valid before a put of a new key must evict. Writes
// are taken at any time but are meant for an idle block.
//
// An item is captured in the input register; the parallel key match, the
// victim search and the state update then load the result register.
// Throughput is one item per cycle while the receiver takes results, set
// by the combinational match and victim compare over all entries.
// When the receiver stalls, the result register holds; the input register
// still takes one more item, and only then does s_tready drop.
// Reset empties the store, selects LRU and sets the capacity to four.
module key_value_cache_replacement_unit
    import kvcr_pkg::*;
#(
    parameter int ENTRIES    = 4,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    // Request items.
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // lookup_key, put_value
    input  logic [0:0]                                    s_tuser,  // action
    // Result items.
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // read_value, victim_key
    output logic [STATUS_W-1:0]                           m_tuser,  // status
    // Register writes.
    input  logic                                          cfg_valid,
    output logic                                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]                          cfg_index,
    input  logic [CFG_DATA_W-1:0]                         cfg_data
);

    localparam int DATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;
    // Ranks of the valid entries are kept dense: 0 newest, used-1 oldest.
    localparam int RANK_W = $clog2(ENTRIES);
    localparam int USED_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (USED_W > CAP_W) ? USED_W : CAP_W;

    // Store.
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [KEY_BITS-1:0]   key_reg   [ENTRIES];
    logic [KEY_BITS-1:0]   key_next  [ENTRIES];
    logic [VALUE_BITS-1:0] value_reg [ENTRIES];
    logic [VALUE_BITS-1:0] value_next[ENTRIES];
    logic [RANK_W-1:0]     rank_reg  [ENTRIES];
    logic [RANK_W-1:0]     rank_next [ENTRIES];
    logic [COUNT_BITS-1:0] count_reg [ENTRIES];
    logic [COUNT_BITS-1:0] count_next[ENTRIES];
    logic [USED_W-1:0]     used_reg, used_next;

    // Configuration.
    policy_t            policy_reg, policy_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;

    // Input register.
    logic                  in_vld_reg;
    logic                  in_put_reg;
    logic [KEY_BITS-1:0]   in_key_reg;
    logic [VALUE_BITS-1:0] in_value_reg;

    // Result register.
    logic                  out_vld_reg;
    status_t               out_status_reg, out_status_next;
    logic [VALUE_BITS-1:0] out_rvalue_reg, out_rvalue_next;
    logic [KEY_BITS-1:0]   out_victim_reg, out_victim_next;

    logic out_ready;
    logic advance;
    logic cfg_write;

    // Lookup and victim search.
    logic [ENTRIES-1:0]    hit_vec;
    logic                  hit_any;
    logic [VALUE_BITS-1:0] hit_value;
    logic [RANK_W-1:0]     hit_rank;
    logic [ENTRIES-1:0]    free_vec;
    logic [ENTRIES-1:0]    victim_vec;
    logic [KEY_BITS-1:0]   victim_key;
    logic [RANK_W-1:0]     victim_rank;
    logic [ENTRIES-1:0]    ins_vec;
    logic [CAP_W-1:0]      cap_eff;
    logic                  need_evict;
    logic                  do_insert;
    logic                  do_evict;
    logic                  do_reorder;

    assign out_ready = !out_vld_reg || m_tready;
    assign advance   = in_vld_reg && out_ready;
    assign s_tready  = !in_vld_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = DATA_W'({out_victim_reg, out_rvalue_reg});

    // Key match; keys of valid entries are unique, so at most one hits.
    always_comb
    begin
        hit_value = '0;
        hit_rank  = '0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            hit_vec[j] = valid_reg[j] && (key_reg[j] == in_key_reg);
            if (hit_vec[j])
            begin
                hit_value = hit_value | value_reg[j];
                hit_rank  = hit_rank | rank_reg[j];
            end
        end
        hit_any = |hit_vec;
    end

    // Lowest free entry: isolate the lowest set bit of the invalid mask.
    assign free_vec = ~valid_reg & (valid_reg + ENTRIES'(1));

    // Victim: the one valid entry that beats every other valid entry.
    always_comb
    begin
        logic beats;
        victim_key  = '0;
        victim_rank = '0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            victim_vec[j] = valid_reg[j];
            for (int k = 0; k < ENTRIES; k++)
            begin
                if (policy_reg == POL_LFU)
                begin
                    beats = (count_reg[j] < count_reg[k]) ||
                            ((count_reg[j] == count_reg[k]) && (rank_reg[j] > rank_reg[k]));
                end
                else
                begin
                    beats = rank_reg[j] > rank_reg[k];
                end
                if (k != j && valid_reg[k] && !beats)
                begin
                    victim_vec[j] = 1'b0;
                end
            end
            if (victim_vec[j])
            begin
                victim_key  = victim_key | key_reg[j];
                victim_rank = victim_rank | rank_reg[j];
            end
        end
    end

    // A capacity of zero behaves as one; above the entry count the full
    // store forces the eviction anyway.
    assign cap_eff    = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign need_evict = (&valid_reg) || (CMP_W'(used_reg) >= CMP_W'(cap_eff));
    assign do_insert  = in_put_reg && !hit_any;
    assign do_evict   = do_insert && need_evict;
    assign do_reorder = hit_any && (policy_reg != POL_FIFO);
    assign ins_vec    = do_evict ? victim_vec : free_vec;

    // Result.
    always_comb
    begin
        out_rvalue_next = '0;
        out_victim_next = '0;
        if (!in_put_reg)
        begin
            out_status_next = hit_any ? ST_HIT : ST_MISS;
            if (hit_any)
            begin
                out_rvalue_next = hit_value;
            end
        end
        else if (hit_any)
        begin
            out_status_next = ST_UPDATED;
        end
        else if (do_evict)
        begin
            out_status_next = ST_EVICTED;
            out_victim_next = victim_key;
        end
        else
        begin
            out_status_next = ST_INSERTED;
        end
    end

    // Store update and configuration.
    always_comb
    begin
        valid_next  = valid_reg;
        used_next   = used_reg;
        policy_next = policy_reg;
        cap_next    = cap_reg;
        for (int j = 0; j < ENTRIES; j++)
        begin
            key_next[j]   = key_reg[j];
            value_next[j] = value_reg[j];
            rank_next[j]  = rank_reg[j];
            count_next[j] = count_reg[j];
        end

        if (advance)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (hit_vec[j])
                begin
                    if (in_put_reg)
                    begin
                        value_next[j] = in_value_reg;
                    end
                    if (count_reg[j] != '1)
                    begin
                        count_next[j] = count_reg[j] + COUNT_BITS'(1);
                    end
                    if (do_reorder)
                    begin
                        rank_next[j] = '0;
                    end
                end
                else if (valid_reg[j] && do_reorder && (rank_reg[j] < hit_rank))
                begin
                    rank_next[j] = rank_reg[j] + RANK_W'(1);
                end

                if (do_insert)
                begin
                    if (ins_vec[j])
                    begin
                        valid_next[j] = 1'b1;
                        key_next[j]   = in_key_reg;
                        value_next[j] = in_value_reg;
                        rank_next[j]  = '0;
                        count_next[j] = COUNT_BITS'(1);
                    end
                    else if (valid_reg[j])
                    begin
                        // Entries older than an evicted one close the gap it
                        // leaves, then everything ages behind the new key.
                        if (do_evict && (rank_reg[j] > victim_rank))
                        begin
                            rank_next[j] = rank_reg[j];
                        end
                        else
                        begin
                            rank_next[j] = rank_reg[j] + RANK_W'(1);
                        end
                    end
                end
            end
            if (do_insert && !do_evict)
            begin
                used_next = used_reg + USED_W'(1);
            end
        end

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_POLICY:
                begin
                    if (cfg_data[POLICY_W-1:0] inside {POL_LRU, POL_LFU, POL_FIFO})
                    begin
                        policy_next = policy_t'(cfg_data[POLICY_W-1:0]);
                        valid_next  = '0;
                        used_next   = '0;
                    end
                end
                CFG_CAPACITY:
                begin
                    cap_next = cfg_data[CAP_W-1:0];
                end
                default:
                begin
                    cap_next = cap_reg;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            used_reg    <= '0;
            policy_reg  <= POL_LRU;
            cap_reg     <= CAP_RESET;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            used_reg   <= used_next;
            policy_reg <= policy_next;
            cap_reg    <= cap_next;
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (out_ready)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ENTRIES; j++)
        begin
            key_reg[j]   <= key_next[j];
            value_reg[j] <= value_next[j];
            rank_reg[j]  <= rank_next[j];
            count_reg[j] <= count_next[j];
        end
        if (s_tready && s_tvalid)
        begin
            in_put_reg   <= s_tuser[0];
            in_key_reg   <= s_tdata[KEY_BITS-1:0];
            in_value_reg <= s_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
        end
        if (advance)
        begin
            out_status_reg <= out_status_next;
            out_rvalue_reg <= out_rvalue_next;
            out_victim_reg <= out_victim_next;
        end
    end

    // Checks.
    a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == USED_W'($countones(valid_reg)))
        else $error("occupancy count disagrees with valid bits");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |-> $onehot0(hit_vec))
        else $error("key present in more than one entry");

    a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && do_evict) |-> $onehot(victim_vec))
        else $error("eviction without a unique victim");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled while a stage is free");

endmodule

### bench/key_value_cache_replacement_unit_tb.sv
`timescale 1ns / 100ps

module key_value_cache_replacement_unit_tb;
    import kvcr_pkg::*;

    localparam int SLOTS       = 4;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int DATA_W      = ((KEY_W + VAL_W + 7) / 8) * 8;
    localparam int HITS_MAX    = 16'hFFFF;
    localparam int POOL_SIZE   = 6;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 45;
    localparam int DRAIN_WAIT  = 4;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SHOW_LIMIT  = 10;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    // The one policy code that the block must drop without clearing the store.
    localparam logic [CFG_DATA_W-1:0] POL_UNUSED = 3'd3;

    typedef struct {
        status_t          status;
        logic [VAL_W-1:0] read_value;
        logic [KEY_W-1:0] victim_key;
    } lookup_result_t;

    // Tracks the store contents and the replacement order, and keeps the
    // results that accepted requests must produce, oldest first.
    class kv_scoreboard;
        policy_t          policy;
        int unsigned      capacity;
        bit               slot_valid [SLOTS];
        logic [KEY_W-1:0] slot_key   [SLOTS];
        logic [VAL_W-1:0] slot_value [SLOTS];
        int unsigned      slot_age   [SLOTS];
        int unsigned      slot_hits  [SLOTS];
        lookup_result_t   expected_q [$];
        int               errors;

        function new();
            policy   = POL_LRU;
            capacity = CAP_RESET;
            errors   = 0;
            flush();
        endfunction

        function void flush();
            for (int j = 0; j < SLOTS; j++)
            begin
                slot_valid[j] = 1'b0;
                slot_age[j]   = 0;
                slot_hits[j]  = 0;
            end
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_POLICY)
            begin
                if (data[POLICY_W-1:0] != POL_UNUSED[POLICY_W-1:0])
                begin
                    policy = policy_t'(data[POLICY_W-1:0]);
                    flush();
                end
            end
            else
            begin
                capacity = data;
            end
        endfunction

        // Entry i becomes the most recent; entries that were more recent age by one.
        function void promote(int i);
            for (int j = 0; j < SLOTS; j++)
                if (slot_valid[j] && j != i && slot_age[j] < slot_age[i])
                    slot_age[j]++;
            slot_age[i] = 0;
        endfunction

        function void touch(int i);
            if (slot_hits[i] < HITS_MAX)
                slot_hits[i]++;
            if (policy != POL_FIFO)
                promote(i);
        endfunction

        function int choose_victim();
            int best;
            best = -1;
            for (int j = 0; j < SLOTS; j++)
            begin
                if (!slot_valid[j])
                    continue;
                if (best < 0)
                    best = j;
                else if (policy == POL_LFU)
                begin
                    if (slot_hits[j] < slot_hits[best] ||
                        (slot_hits[j] == slot_hits[best] && slot_age[j] > slot_age[best]))
                        best = j;
                end
                else if (slot_age[j] > slot_age[best])
                    best = j;
            end
            return best;
        endfunction

        function void note_request(logic act, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
            lookup_result_t r;
            int found, used, free_slot, victim;
            int unsigned limit;
            found     = -1;
            used      = 0;
            free_slot = -1;
            r.status     = ST_MISS;
            r.read_value = '0;
            r.victim_key = '0;
            for (int j = 0; j < SLOTS; j++)
            begin
                if (slot_valid[j])
                begin
                    used++;
                    if (slot_key[j] == key)
                        found = j;
                end
                else if (free_slot < 0)
                begin
                    free_slot = j;
                end
            end
            if (act == ACT_GET)
            begin
                if (found >= 0)
                begin
                    r.status     = ST_HIT;
                    r.read_value = slot_value[found];
                    touch(found);
                end
            end
            else if (found >= 0)
            begin
                slot_value[found] = val;
                touch(found);
                r.status = ST_UPDATED;
            end
            else
            begin
                // A capacity of zero behaves as one, anything above the size as full size.
                limit = (capacity < 1) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
                r.status = ST_INSERTED;
                if (used >= limit || free_slot < 0)
                begin
                    victim = choose_victim();
                    if (victim >= 0)
                    begin
                        r.victim_key       = slot_key[victim];
                        slot_valid[victim] = 1'b0;
                        free_slot          = victim;
                        r.status           = ST_EVICTED;
                    end
                end
                if (free_slot >= 0)
                begin
                    for (int j = 0; j < SLOTS; j++)
                        if (slot_valid[j])
                            slot_age[j]++;
                    slot_valid[free_slot] = 1'b1;
                    slot_key[free_slot]   = key;
                    slot_value[free_slot] = val;
                    slot_age[free_slot]   = 0;
                    slot_hits[free_slot]  = 1;
                end
            end
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] data);
            lookup_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("Unexpected result item: status %0d data %h", status, data);
                return;
            end
            e = expected_q[0];
            expected_q.delete(0);
            if (status !== e.status || data[VAL_W-1:0] !== e.read_value ||
                data[VAL_W+KEY_W-1:VAL_W] !== e.victim_key)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display({"Mismatch: status exp %0d act %0d, value exp %h act %h, ",
                              "victim exp %h act %h"},
                             e.status, status, e.read_value, data[VAL_W-1:0],
                             e.victim_key, data[VAL_W+KEY_W-1:VAL_W]);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;   // lookup_key, put_value
    logic [0:0]            s_tuser = '0;   // action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;        // read_value, victim_key
    logic [STATUS_W-1:0]   m_tuser;        // status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    kv_scoreboard sb;
    int           cycle_count = 0;
    int           tx_count = 0;
    int           rx_count = 0;
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    key_value_cache_replacement_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // All three channels are observed at the edge, before any driver updates land.
    // A result is checked before a request of the same edge is noted; that request
    // must still pass the input and result registers, so it can never own the result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser[0], s_tdata[KEY_W-1:0],
                                s_tdata[KEY_W+VAL_W-1:KEY_W]);
            if (cfg_valid && cfg_ready)
                sb.apply_register(cfg_index, cfg_data);
        end
    end

    // Receiver: random stalls per result item, with calm stretches where it
    // takes every item at once.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_count % 16 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            stall = rx_calm ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            rx_count++;
        end
    end

    // Sends one request item after a random gap and returns at the edge that takes it.
    task automatic send_request(input logic act, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] val);
        int gap;
        if (tx_count % 16 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {val, key};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tx_count++;
    endtask

    // Holds off new requests until every outstanding result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly keys from a small pool so that hits, updates and evictions are
    // common; a few keys are fresh or sit at the extremes of the key range.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 4)
            return $urandom;
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic run_directed();
        // Reset state: LRU with all four entries usable. Field extremes first.
        send_request(ACT_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(ACT_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(ACT_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(ACT_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_request(ACT_PUT, 32'h1111_0001, 32'h0000_0101);
        send_request(ACT_PUT, 32'h1111_0002, 32'h0000_0202);
        // Store is full here, so a new key evicts the least recently touched one.
        send_request(ACT_PUT, 32'h1111_0003, 32'h0000_0303);
        send_request(ACT_GET, 32'h1111_0003, 32'hDEAD_BEEF);
        settle();

        // The unused policy code is dropped and the store survives.
        write_reg(CFG_POLICY, POL_UNUSED);
        send_request(ACT_GET, 32'h1111_0003, 32'h0000_0000);
        settle();

        // Zero capacity behaves as one and lies below the current occupancy,
        // so each new key evicts exactly one entry.
        write_reg(CFG_CAPACITY, 3'd0);
        send_request(ACT_PUT, 32'h1111_0004, 32'h0000_0404);
        send_request(ACT_PUT, 32'h1111_0005, 32'h0000_0505);
        send_request(ACT_GET, 32'h1111_0004, 32'h0000_0000);
        settle();

        // FIFO: touches and updates leave the insertion order alone.
        write_reg(CFG_POLICY, {1'b0, POL_FIFO});
        write_reg(CFG_CAPACITY, 3'd2);
        send_request(ACT_PUT, 32'h2222_0001, 32'h0000_0011);
        send_request(ACT_PUT, 32'h2222_0002, 32'h0000_0022);
        send_request(ACT_GET, 32'h2222_0001, 32'h0000_0000);
        send_request(ACT_PUT, 32'h2222_0001, 32'h0000_0033);
        send_request(ACT_PUT, 32'h2222_0003, 32'h0000_0044);
        settle();

        // LFU: the entry touched most survives; among equal counts the older goes.
        write_reg(CFG_POLICY, {1'b0, POL_LFU});
        send_request(ACT_PUT, 32'h3333_0001, 32'h0000_0011);
        send_request(ACT_GET, 32'h3333_0001, 32'h0000_0000);
        send_request(ACT_PUT, 32'h3333_0002, 32'h0000_0022);
        send_request(ACT_PUT, 32'h3333_0003, 32'h0000_0033);
        send_request(ACT_PUT, 32'h3333_0004, 32'h0000_0044);
        settle();
    endtask

    // Each phase sets a policy and a capacity, then runs random gets and puts.
    // The policy writes also use the top data bit, and the list reaches every
    // capacity code including zero and the values above the store size.
    initial
    begin
        logic [CFG_DATA_W-1:0] phase_policy [PHASES];
        logic [CFG_DATA_W-1:0] phase_cap    [PHASES];
        logic                  act;
        sb = new();
        phase_policy = '{{1'b0, POL_LRU}, {1'b0, POL_LFU}, {1'b0, POL_FIFO},
                         {1'b0, POL_LRU}, {1'b0, POL_LFU}, {1'b0, POL_FIFO},
                         {1'b1, POL_LFU}, {1'b1, POL_FIFO}, POL_UNUSED,
                         {1'b1, POL_LRU}};
        phase_cap    = '{3'd4, 3'd4, 3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(CFG_POLICY, phase_policy[p]);
            write_reg(CFG_CAPACITY, phase_cap[p]);
            for (int k = 0; k < POOL_SIZE; k++)
                key_pool[k] = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                act = ($urandom_range(0, 9) < 5) ? ACT_PUT : ACT_GET;
                send_request(act, pick_key(), $urandom);
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
